@@ rtl/sitp_pkg.sv @@
package sitp_pkg;

  // character codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // radix codes
  localparam logic [5:0] BASE_AUTO  = 6'd0;
  localparam logic [5:0] BASE_OCT   = 6'd8;
  localparam logic [5:0] BASE_DEC   = 6'd10;
  localparam logic [5:0] BASE_HEX   = 6'd16;
  localparam logic [5:0] BASE_MAX   = 6'd36;
  localparam logic [5:0] BASE_RESET = BASE_DEC;

  // character count limit
  localparam int unsigned MAX_LEN = 255;
  localparam int unsigned COUNT_LIMIT = (MAX_LEN < 255) ? MAX_LEN : 255;
  localparam logic [7:0] COUNT_CAP = 8'(COUNT_LIMIT);

  typedef enum logic [3:0] {
    PH_BLANK  = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_HEXPFX = 4'b1000
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       string_start;
  } in_item_t;

  typedef struct packed {
    logic              parse_done;
    logic signed [31:0] parsed_value;
    logic [7:0]        end_offset;
  } out_item_t;

  typedef struct packed {
    parse_phase_e phase;
    logic         negative;
    logic [31:0]  acc;
    logic [5:0]   base;
    logic         undecided;
    logic [7:0]   count;
    logic         finished;
  } parse_state_t;

  typedef struct packed {
    logic        done;
    logic        negative;
    logic [31:0] mag;
    logic [7:0]  count;
  } step_res_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase:     PH_BLANK,
    negative:  1'b0,
    acc:       32'd0,
    base:      6'd0,
    undecided: 1'b0,
    count:     8'd0,
    finished:  1'b0
  };

endpackage

@@ rtl/sitp_step.sv @@
module sitp_step (
  input  sitp_pkg::parse_state_t state_i,
  input  sitp_pkg::in_item_t     item_i,
  input  logic [5:0]             number_base_i,
  output sitp_pkg::parse_state_t state_o,
  output sitp_pkg::step_res_t    res_o
);

  sitp_pkg::parse_state_t cur;
  sitp_pkg::parse_state_t nxt;
  logic       done;
  logic [7:0] c;
  logic [7:0] c_off;
  logic       dv;
  logic [5:0] dval;
  logic       blank;
  logic [7:0] cnt_inc;
  logic [7:0] cnt_dec;
  logic [5:0] b_eff;
  logic       fd_ok;
  logic [5:0] fd_base;
  logic       fd_undec;
  logic [5:0] mul_base;
  logic [31:0] mac;
  logic       is_x;

  // a new string starts from a cleared state
  assign cur = item_i.string_start ? sitp_pkg::STATE_CLEAR : state_i;
  assign c   = item_i.char_code;

  // digit decode
  always_comb begin
    dv    = 1'b1;
    c_off = 8'd0;
    if (c >= sitp_pkg::CH_0 && c <= sitp_pkg::CH_9) begin
      c_off = c - sitp_pkg::CH_0;
    end else if (c >= sitp_pkg::CH_UA && c <= sitp_pkg::CH_UZ) begin
      c_off = c - sitp_pkg::CH_UA + 8'd10;
    end else if (c >= sitp_pkg::CH_LA && c <= sitp_pkg::CH_LZ) begin
      c_off = c - sitp_pkg::CH_LA + 8'd10;
    end else begin
      dv = 1'b0;
    end
    dval = c_off[5:0];
  end

  assign blank = (c == sitp_pkg::CH_SPACE) || (c >= sitp_pkg::CH_TAB && c <= sitp_pkg::CH_CR);
  assign is_x  = (c == sitp_pkg::CH_LX) || (c == sitp_pkg::CH_UX);

  // saturating count and the step back for a dangling x
  assign cnt_inc = (cur.count < sitp_pkg::COUNT_CAP) ? cur.count + 8'd1 : cur.count;
  assign cnt_dec = (cur.count != 8'd0) ? cur.count - 8'd1 : 8'd0;

  // radix selection at the first digit
  assign b_eff = (number_base_i > sitp_pkg::BASE_MAX) ? sitp_pkg::BASE_MAX : number_base_i;

  always_comb begin
    if (b_eff == sitp_pkg::BASE_AUTO) begin
      fd_ok    = (c == sitp_pkg::CH_0) ||
                 (dv && dval >= 6'd1 && dval <= 6'd9 && c <= sitp_pkg::CH_9);
      fd_base  = (c == sitp_pkg::CH_0) ? sitp_pkg::BASE_OCT : sitp_pkg::BASE_DEC;
      fd_undec = (c == sitp_pkg::CH_0);
    end else begin
      fd_ok    = dv && (dval < b_eff);
      fd_base  = b_eff;
      fd_undec = (b_eff == sitp_pkg::BASE_HEX) && (c == sitp_pkg::CH_0);
    end
  end

  // one multiply-add per character
  assign mul_base = (cur.phase == sitp_pkg::PH_HEXPFX) ? sitp_pkg::BASE_HEX : cur.base;
  assign mac      = 32'(cur.acc * 32'(mul_base)) + 32'(dval);

  // phase sequencing
  always_comb begin
    nxt  = cur;
    done = 1'b0;
    if (!cur.finished) begin
      unique case (cur.phase)
        sitp_pkg::PH_BLANK, sitp_pkg::PH_SIGN: begin
          if (blank) begin
            nxt.count = cnt_inc;
          end else if (cur.phase == sitp_pkg::PH_BLANK && c == sitp_pkg::CH_MINUS) begin
            nxt.negative = 1'b1;
            nxt.phase    = sitp_pkg::PH_SIGN;
            nxt.count    = cnt_inc;
          end else if (cur.phase == sitp_pkg::PH_BLANK && c == sitp_pkg::CH_PLUS) begin
            nxt.phase = sitp_pkg::PH_SIGN;
            nxt.count = cnt_inc;
          end else if (fd_ok) begin
            nxt.base      = fd_base;
            nxt.undecided = fd_undec;
            nxt.acc       = 32'(dval);
            nxt.phase     = sitp_pkg::PH_DIGITS;
            nxt.count     = cnt_inc;
          end else begin
            nxt.acc      = 32'd0;
            nxt.count    = 8'd0;
            nxt.finished = 1'b1;
            done         = 1'b1;
          end
        end
        sitp_pkg::PH_DIGITS: begin
          nxt.undecided = 1'b0;
          if (cur.undecided && is_x) begin
            nxt.base  = sitp_pkg::BASE_HEX;
            nxt.phase = sitp_pkg::PH_HEXPFX;
            nxt.count = cnt_inc;
          end else if (dv && dval < cur.base) begin
            nxt.acc   = mac;
            nxt.count = cnt_inc;
          end else begin
            nxt.finished = 1'b1;
            done         = 1'b1;
          end
        end
        sitp_pkg::PH_HEXPFX: begin
          if (dv && dval < sitp_pkg::BASE_HEX) begin
            nxt.acc   = mac;
            nxt.phase = sitp_pkg::PH_DIGITS;
            nxt.count = cnt_inc;
          end else begin
            nxt.count    = cnt_dec;
            nxt.finished = 1'b1;
            done         = 1'b1;
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

  assign state_o = nxt;

  always_comb begin
    res_o.done     = done;
    res_o.negative = nxt.negative;
    res_o.mag      = nxt.acc;
    res_o.count    = nxt.count;
  end

endmodule

@@ rtl/signed_integer_text_parser.sv @@
// Streaming signed integer parser, one character per transfer.
// Input channel (in_valid_i/in_ready_o/in_data_i) carries a character code and a
// string_start flag that clears the parse state before the character is used.
// Output channel (out_valid_o/out_ready_i/out_data_o) returns one result per
// character: parse_done marks the character that ends the number, parsed_value
// is the running or final signed value and end_offset the consumed count.
// An input transfer reaches the output through one input register, then one
// pass through the step logic into the result register. Throughput is one
// character per cycle while the receiver does not stall; the parse state loop
// (one 32x6 multiply-add plus phase decode) is one combinational pass.
// When the receiver stalls, the result register holds and the input register
// takes one more character; after that in_ready_o drops until the output moves.
// Reset clears both registers' valid bits, the parse state and sets the radix
// register to 10. cfg_we_i writes number_base (0 selects auto-detection); it is
// meant to be written only while no character is in flight.
module signed_integer_text_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sitp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sitp_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [5:0]          cfg_wdata_i
);

  logic                   s0_valid_q;
  sitp_pkg::in_item_t     s0_item_q;
  logic                   res_valid_q;
  sitp_pkg::step_res_t    res_q;
  sitp_pkg::step_res_t    res_d;
  sitp_pkg::parse_state_t st_q;
  sitp_pkg::parse_state_t st_d;
  logic [5:0]             base_q;
  logic                   advance;

  // step moves when the result register is free or being drained
  assign advance    = s0_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !s0_valid_q || advance;

  sitp_step u_step (
    .state_i       (st_q),
    .item_i        (s0_item_q),
    .number_base_i (base_q),
    .state_o       (st_d),
    .res_o         (res_d)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      st_q        <= sitp_pkg::STATE_CLEAR;
      base_q      <= sitp_pkg::BASE_RESET;
    end else begin
      if (in_ready_o) begin
        s0_valid_q <= in_valid_i;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s0_item_q <= in_data_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // output with sign applied
  assign out_valid_o             = res_valid_q;
  assign out_data_o.parse_done   = res_q.done;
  assign out_data_o.parsed_value = $signed(res_q.negative ? (32'd0 - res_q.mag) : res_q.mag);
  assign out_data_o.end_offset   = res_q.count;

  // a reported end leaves the parse finished
  a_done_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d.done) |=> st_q.finished)
    else $error("parse end did not latch finished");

  // no second end without a new string
  a_single_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && st_q.finished && !s0_item_q.string_start) |-> !res_d.done)
    else $error("second parse end within one string");

  // count stays within its cap
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.count <= sitp_pkg::COUNT_CAP)
    else $error("consumed count above cap");

  // input back-pressure only when both stages are full and output stalls
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s0_valid_q && res_valid_q && !out_ready_i))
    else $error("input stalled without cause");

endmodule
